// ===== src/rrss_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, request codes, command/status and payload types
// for the round-robin slice scheduler; no dependencies
package rrss_pkg;

	localparam int MAX_TASKS = 64;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = IDX_W + 1;
	localparam int TIME_W    = 32;
	localparam int WAIT_W    = 40;
	localparam int QUANT_W   = 16;
	localparam int TIDX_W    = 6;

	localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd4;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_SLICE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] arrive_at;
		logic [15:0] burst_len;
	} rrss_item_t;

	typedef struct packed {
		logic                     slice_valid;
		logic [TIDX_W-1:0]        task_index;
		logic [TIME_W-1:0]        slice_start;
		logic [TIME_W-1:0]        slice_end;
		logic signed [WAIT_W-1:0] wait_sum;
		logic                     all_done;
	} rrss_result_t;

	// controller -> datapath
	typedef struct packed {
		logic append;
		logic clear;
		logic scan_start;
		logic scan_run;
		logic calc;
		logic commit;
		logic respond_none;
	} rrss_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic active_zero;
		logic hit;
		logic out_free;
	} rrss_status_t;

endpackage

// ===== src/rrss_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read memory with registered read data
// no dependencies
module rrss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                           clk,
	input  logic                                           we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
	input  logic [WIDTH-1:0]                               wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
	output logic [WIDTH-1:0]                               rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/rrss_ctrl.sv =====
`timescale 1ns / 1ps
// scheduler controller: request decode and slice sequencing
// depends on rrss_pkg
module rrss_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic [1:0]            req_type,
	output logic                  item_ready,
	input  rrss_pkg::rrss_status_t st,
	output rrss_pkg::rrss_cmd_t    cmd
);
	import rrss_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_CALC   = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_NONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_APPEND: cmd.append = 1'b1;
						REQ_CLEAR:  cmd.clear  = 1'b1;
						REQ_SLICE: begin
							if (st.active_zero) begin
								state_d = S_NONE;
							end else begin
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				// hit cycle captures the entry, otherwise keep walking
				if (st.hit) begin
					state_d = S_CALC;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_COMMIT;
			end
			S_COMMIT: begin
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_NONE: begin
				if (st.out_free) begin
					cmd.respond_none = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/rrss_dp.sv =====
`timescale 1ns / 1ps
// scheduler datapath: task table memories, scan pointer, time and wait
// accumulators, result register; depends on rrss_pkg and rrss_ram
module rrss_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rrss_pkg::rrss_cmd_t    cmd,
	output rrss_pkg::rrss_status_t st,
	input  rrss_pkg::rrss_item_t   item,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_data,
	input  logic                   result_ready,
	output logic                   result_valid,
	output rrss_pkg::rrss_result_t result
);
	import rrss_pkg::*;

	logic [CNT_W-1:0]   task_count_q;
	logic [CNT_W-1:0]   scan_ptr_q;
	logic [CNT_W-1:0]   active_q;
	logic [TIME_W-1:0]  cur_time_q;
	logic [WAIT_W-1:0]  wait_q;
	logic [QUANT_W-1:0] quantum_q;

	logic [IDX_W-1:0]   scan_addr_q;
	logic [IDX_W-1:0]   chk_idx_s1;
	logic               chk_vld_s1;

	logic [IDX_W-1:0]   idx_q;
	logic [QUANT_W-1:0] rem_q;
	logic [TIME_W-1:0]  ready_q;
	logic [TIME_W-1:0]  end_q;
	logic [QUANT_W-1:0] new_rem_q;
	logic [WAIT_W-1:0]  diff_q;

	logic               result_valid_q;
	rrss_result_t       result_q;

	logic [TIME_W-1:0]  ready_rd;
	logic [QUANT_W-1:0] rem_rd;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [TIME_W-1:0]  ready_wdata;
	logic [QUANT_W-1:0] rem_wdata;

	logic               full;
	logic               do_append;
	logic [CNT_W-1:0]   addr_inc;
	logic [QUANT_W-1:0] quantum_eff;
	logic [QUANT_W-1:0] slice_len;
	logic               finished;
	logic [CNT_W-1:0]   active_nxt;
	logic [WAIT_W-1:0]  wait_nxt;
	logic [IDX_W+TIDX_W-1:0] idx_wide;

	assign full      = (task_count_q == CNT_W'(MAX_TASKS));
	assign do_append = cmd.append && !full;
	assign addr_inc  = {1'b0, scan_addr_q} + CNT_W'(1);

	assign st.active_zero = (active_q == '0);
	assign st.hit         = chk_vld_s1 && (rem_rd != '0);
	assign st.out_free    = !result_valid_q || result_ready;

	// table write port: appends in idle, slice updates at commit
	always_comb begin
		ram_we      = do_append || cmd.commit;
		ram_waddr   = cmd.commit ? idx_q : task_count_q[IDX_W-1:0];
		ready_wdata = cmd.commit ? end_q : {16'd0, item.arrive_at};
		rem_wdata   = cmd.commit ? new_rem_q : item.burst_len;
	end

	rrss_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_ready_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ready_wdata),
		.raddr (scan_addr_q),
		.rdata (ready_rd)
	);

	rrss_ram #(.WIDTH(QUANT_W), .DEPTH(MAX_TASKS)) u_rem_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rem_wdata),
		.raddr (scan_addr_q),
		.rdata (rem_rd)
	);

	assign quantum_eff = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
	assign slice_len   = (rem_q < quantum_eff) ? rem_q : quantum_eff;
	assign finished    = (new_rem_q == '0);
	assign active_nxt  = active_q - CNT_W'(finished);
	assign wait_nxt    = wait_q + diff_q;
	assign idx_wide    = {{TIDX_W{1'b0}}, idx_q};

	// scan walk and entry capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			chk_vld_s1  <= 1'b0;
		end else begin
			chk_vld_s1 <= cmd.scan_run;
			if (cmd.scan_start) begin
				scan_addr_q <= (scan_ptr_q >= task_count_q) ? '0 : scan_ptr_q[IDX_W-1:0];
			end else if (cmd.scan_run) begin
				scan_addr_q <= (addr_inc == task_count_q) ? '0 : addr_inc[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= scan_addr_q;
		if (st.hit) begin
			idx_q   <= chk_idx_s1;
			rem_q   <= rem_rd;
			ready_q <= ready_rd;
		end
		if (cmd.calc) begin
			end_q     <= cur_time_q + TIME_W'(slice_len);
			new_rem_q <= rem_q - slice_len;
			// wraps modulo 2^40, negative when the task has not arrived yet
			diff_q    <= {8'd0, cur_time_q} - {8'd0, ready_q};
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			scan_ptr_q   <= '0;
			active_q     <= '0;
			cur_time_q   <= '0;
			wait_q       <= '0;
			quantum_q    <= QUANTUM_RESET;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_data;
			end
			if (cmd.clear) begin
				task_count_q <= '0;
				scan_ptr_q   <= '0;
				active_q     <= '0;
				cur_time_q   <= '0;
				wait_q       <= '0;
			end else if (do_append) begin
				task_count_q <= task_count_q + CNT_W'(1);
				if (item.burst_len != '0) begin
					active_q <= active_q + CNT_W'(1);
				end
			end else if (cmd.commit) begin
				scan_ptr_q <= {1'b0, idx_q} + CNT_W'(1);
				active_q   <= active_nxt;
				cur_time_q <= end_q;
				wait_q     <= wait_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.respond_none) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.slice_valid <= 1'b1;
			result_q.task_index  <= idx_wide[TIDX_W-1:0];
			result_q.slice_start <= cur_time_q;
			result_q.slice_end   <= end_q;
			result_q.wait_sum    <= wait_nxt;
			result_q.all_done    <= (active_nxt == '0);
		end else if (cmd.respond_none) begin
			result_q.slice_valid <= 1'b0;
			result_q.task_index  <= '0;
			result_q.slice_start <= '0;
			result_q.slice_end   <= '0;
			result_q.wait_sum    <= wait_q;
			result_q.all_done    <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== src/round_robin_slice_scheduler_top.sv =====
`timescale 1ns / 1ps
// Round-robin slice scheduler with a configurable quantum. Appends and
// clears return nothing. A slice request returns one result; the time
// it takes grows with the number of table entries walked (1 up to the
// task count) from the scan pointer to the next unfinished task, since
// the remaining-burst memory is scanned one entry per cycle. A request
// when no task is left answers without a scan. The block takes the next
// request while an earlier result still waits.
// depends on rrss_pkg, rrss_ctrl, rrss_dp
module round_robin_slice_scheduler_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  rrss_pkg::rrss_item_t  item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output rrss_pkg::rrss_result_t result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data
);
	import rrss_pkg::*;

	rrss_cmd_t    cmd;
	rrss_status_t st;

	// quantum writes land at any time
	assign cfg_ready = 1'b1;

	rrss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.req_type   (item.req_type),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	rrss_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== tb/rrss_slice_checker.sv =====
`timescale 1ns / 1ps
// slice checker: watches the request, result and quantum channels of the
// round-robin slice scheduler, predicts each slice and compares it
// depends on rrss_pkg
module rrss_slice_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_ready,
	input  rrss_pkg::rrss_item_t   item,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  rrss_pkg::rrss_result_t result,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [15:0]            cfg_data,
	output int                     errors,
	output int                     pending
);
	import rrss_pkg::*;

	logic [TIME_W-1:0]  ready_at [MAX_TASKS];
	logic [QUANT_W-1:0] burst_left [MAX_TASKS];
	int unsigned        loaded;
	int unsigned        next_pos;
	logic [TIME_W-1:0]  clock_now;
	logic [WAIT_W-1:0]  wait_acc;
	logic [QUANT_W-1:0] quantum;
	rrss_result_t       slice_q [$];
	rrss_result_t       want;
	int                 fail_count = 0;

	assign errors = fail_count;

	// runs one slice on the model table and returns what the block should report
	function automatic rrss_result_t next_slice();
		rrss_result_t       r;
		int unsigned        first;
		int unsigned        c;
		int unsigned        pick;
		logic               found;
		logic [QUANT_W-1:0] q;
		r = '0;
		found = 1'b0;
		pick = 0;
		first = (next_pos >= loaded) ? 0 : next_pos;
		for (int k = 0; k < loaded; k++) begin
			c = first + k;
			if (c >= loaded)
				c -= loaded;
			if (!found && burst_left[c] != 0) begin
				found = 1'b1;
				pick = c;
			end
		end
		if (!found) begin
			r.wait_sum = wait_acc;
			r.all_done = 1'b1;
			return r;
		end
		q = (quantum == 0) ? 16'd1 : quantum;
		r.slice_valid = 1'b1;
		r.task_index = pick[TIDX_W-1:0];
		r.slice_start = clock_now;
		if (burst_left[pick] < q) begin
			r.slice_end = clock_now + burst_left[pick];
			burst_left[pick] = '0;
		end else begin
			r.slice_end = clock_now + q;
			burst_left[pick] = burst_left[pick] - q;
		end
		// wait may go negative when the task has not arrived yet
		wait_acc = wait_acc + {8'd0, clock_now} - {8'd0, ready_at[pick]};
		ready_at[pick] = r.slice_end;
		clock_now = r.slice_end;
		next_pos = pick + 1;
		r.wait_sum = wait_acc;
		r.all_done = 1'b1;
		for (int i = 0; i < loaded; i++)
			if (burst_left[i] != 0)
				r.all_done = 1'b0;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded = 0;
			next_pos = 0;
			clock_now = '0;
			wait_acc = '0;
			quantum = QUANTUM_RESET;
			slice_q.delete();
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (slice_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
				end else begin
					want = slice_q.pop_front();
					check_field("slice_valid", want.slice_valid, result.slice_valid);
					check_field("task_index", want.task_index, result.task_index);
					check_field("slice_start", want.slice_start, result.slice_start);
					check_field("slice_end", want.slice_end, result.slice_end);
					check_field("wait_sum", want.wait_sum, result.wait_sum);
					check_field("all_done", want.all_done, result.all_done);
				end
			end
			if (cfg_valid && cfg_ready)
				quantum = cfg_data;
			if (item_valid && item_ready) begin
				case (item.req_type)
					REQ_APPEND: begin
						// a full table drops the request
						if (loaded < MAX_TASKS) begin
							ready_at[loaded] = {16'd0, item.arrive_at};
							burst_left[loaded] = item.burst_len;
							loaded++;
						end
					end
					REQ_SLICE: slice_q.push_back(next_slice());
					REQ_CLEAR: begin
						loaded = 0;
						next_pos = 0;
						clock_now = '0;
						wait_acc = '0;
					end
					default: ;
				endcase
			end
			pending <= slice_q.size();
		end
	end

endmodule

// ===== tb/tb_round_robin_slice_scheduler_top.sv =====
`timescale 1ns / 1ps
// testbench top for the round-robin slice scheduler: drives task loads, clears,
// slice requests and quantum writes with random idling, then gives the verdict
// depends on rrss_pkg, rrss_slice_checker and round_robin_slice_scheduler_top
module tb_round_robin_slice_scheduler_top;
	import rrss_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 1450;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int CALM_FIRST    = 700;
	localparam int CALM_LAST     = 900;
	localparam int PHASE_LEN     = 220;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	rrss_item_t         item = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	rrss_result_t       result;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        cfg_data = '0;
	int                 errors;
	int                 pending;
	int                 sent_count = 0;
	int unsigned        cycle_count = 0;
	logic               calm = 1'b0;
	logic [QUANT_W-1:0] cur_quantum = QUANTUM_RESET;

	round_robin_slice_scheduler_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	rrss_slice_checker slice_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		result_ready <= calm || ($urandom_range(99) >= 32);
	end

	task automatic push_request(input logic [1:0] kind, input logic [15:0] arr,
			input logic [15:0] burst);
		rrss_item_t req;
		logic       quiet;
		req.req_type = kind;
		req.arrive_at = arr;
		req.burst_len = burst;
		quiet = (sent_count >= CALM_FIRST) && (sent_count < CALM_LAST);
		calm <= quiet;
		while (!quiet && $urandom_range(99) < 32) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (!item_ready);
		sent_count++;
	endtask

	// hold off new requests until every slice has come back, then let the block settle
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [15:0] q);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= q;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_quantum = q;
	endtask

	// mostly a load of tasks followed by slice requests, sometimes plain noise
	task automatic run_task_set();
		int          roll;
		int          ntask;
		int          slices;
		int          pick;
		int unsigned qe;
		int unsigned lim;
		logic [15:0] arr;
		logic [15:0] burst;
		qe = (cur_quantum == 0) ? 1 : cur_quantum;
		lim = (qe * 3 > 65535) ? 65535 : qe * 3;
		roll = $urandom_range(99);
		if (roll < 78) begin
			if ($urandom_range(99) < 70)
				push_request(REQ_CLEAR, 16'($urandom), 16'($urandom));
			ntask = ($urandom_range(99) < 4) ? $urandom_range(60, 70) : $urandom_range(1, 8);
			slices = 2;
			for (int t = 0; t < ntask; t++) begin
				arr = ($urandom_range(99) < 25) ? 16'($urandom) : 16'($urandom_range(40));
				burst = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(lim));
				push_request(REQ_APPEND, arr, burst);
				slices += burst / qe + 1;
			end
			if (slices > 150)
				slices = 150;
			for (int s = 0; s < slices; s++) begin
				pick = $urandom_range(99);
				if (pick < 6)
					push_request(REQ_APPEND, 16'($urandom), 16'($urandom_range(lim)));
				else if (pick < 9)
					push_request(REQ_UNUSED, 16'($urandom), 16'($urandom));
				else
					push_request(REQ_SLICE, 16'($urandom), 16'($urandom));
			end
		end else begin
			ntask = $urandom_range(1, 6);
			for (int t = 0; t < ntask; t++)
				push_request(2'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int base;
		int phase_no;
		int phase_mark;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset quantum: zero burst, unknown request, negative wait, late append
		push_request(REQ_APPEND, 16'd0, 16'd5);
		push_request(REQ_APPEND, 16'hffff, 16'd0);
		push_request(REQ_APPEND, 16'd3, 16'hffff);
		push_request(REQ_UNUSED, 16'hffff, 16'hffff);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		push_request(REQ_APPEND, 16'd60000, 16'd2);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		// empty table, then all tasks finished
		push_request(REQ_CLEAR, 16'd0, 16'd0);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		push_request(REQ_APPEND, 16'd0, 16'd1);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		// zero quantum runs as one
		write_quantum(16'd0);
		push_request(REQ_APPEND, 16'd10, 16'd3);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		write_quantum(16'hffff);
		push_request(REQ_APPEND, 16'd0, 16'hffff);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		push_request(REQ_APPEND, 16'hffff, 16'hfffe);
		push_request(REQ_SLICE, 16'd0, 16'd0);
		push_request(REQ_CLEAR, 16'hffff, 16'hffff);

		base = sent_count;
		phase_no = 0;
		phase_mark = base;
		while (sent_count < base + RANDOM_ITEMS) begin
			if (sent_count >= phase_mark) begin
				phase_mark += PHASE_LEN;
				case (phase_no % 6)
					0: write_quantum(16'd1);
					1: write_quantum(16'($urandom_range(2, 12)));
					2: write_quantum(16'd0);
					3: write_quantum(16'hffff);
					4: write_quantum(16'($urandom_range(1, 200)));
					default: write_quantum(QUANTUM_RESET);
				endcase
				phase_no++;
			end
			run_task_set();
		end

		drain_results();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rrss_pkg.sv
src/rrss_ram.sv
src/rrss_ctrl.sv
src/rrss_dp.sv
src/round_robin_slice_scheduler_top.sv
tb/rrss_slice_checker.sv
tb/tb_round_robin_slice_scheduler_top.sv
